// ===== src/atrlf_pkg.sv =====
// shared types and constants for the reply and length frame parser
// no dependencies; used by the interfaces, core, output buffer and top level
`default_nettype none

package atrlf_pkg;

	localparam int unsigned ByteW = 8;

	typedef logic [ByteW-1:0] byte_t;

	// characters of interest in module replies
	localparam byte_t CharGt = 8'h3E;
	localparam byte_t CharO  = 8'h4F;
	localparam byte_t CharK  = 8'h4B;

	// a header is only recognized beyond this buffer position
	localparam byte_t HeaderMinPos = 8'd3;

	// one result item
	typedef struct packed {
		logic  ok_seen;
		logic  frame_start;
		byte_t frame_length;
		logic  msg_valid;
		byte_t msg_byte;
		byte_t msg_index;
		logic  msg_last;
	} res_t;

endpackage

`default_nettype wire

// ===== src/atrlf_rx_if.sv =====
// receive byte channel: valid/ready handshake carrying one byte per request
// depends on atrlf_pkg
`default_nettype none

interface atrlf_rx_if;
	logic             valid;
	logic             ready;
	atrlf_pkg::byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== src/atrlf_res_if.sv =====
// result channel: valid/ready handshake carrying the parser outputs
// depends on atrlf_pkg
`default_nettype none

interface atrlf_res_if;
	logic             valid;
	logic             ready;
	logic             ok_seen;
	logic             frame_start;
	atrlf_pkg::byte_t frame_length;
	logic             msg_valid;
	atrlf_pkg::byte_t msg_byte;
	atrlf_pkg::byte_t msg_index;
	logic             msg_last;

	modport source (output valid, output ok_seen, output frame_start, output frame_length,
		output msg_valid, output msg_byte, output msg_index, output msg_last, input ready);
	modport sink (input valid, input ok_seen, input frame_start, input frame_length,
		input msg_valid, input msg_byte, input msg_index, input msg_last, output ready);
	modport monitor (input valid, input ready, input ok_seen, input frame_start,
		input frame_length, input msg_valid, input msg_byte, input msg_index,
		input msg_last);
endinterface

`default_nettype wire

// ===== src/atrlf_core.sv =====
// parser state and single-pass next-state / result logic, one byte per cycle while in_fire is high
// depends on atrlf_pkg
`default_nettype none

module atrlf_core #(
	parameter int unsigned WRAP_LIMIT = 150
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_wdata,
	input  wire logic             in_fire,
	input  wire atrlf_pkg::byte_t rx_byte,
	output atrlf_pkg::res_t       res
);

	localparam logic [atrlf_pkg::ByteW:0] WrapLimit = (atrlf_pkg::ByteW + 1)'(WRAP_LIMIT);

	logic             reply_mode_q;
	atrlf_pkg::byte_t pos_q, prev_q, prev2_q, remaining_q, msg_idx_q;
	logic             zero_seen_q;

	atrlf_pkg::byte_t pos_d, prev_d, prev2_d, remaining_d, msg_idx_d;
	logic             zero_seen_d;

	logic                        hit;
	logic [atrlf_pkg::ByteW:0]   pos_inc;
	logic                        wrap;
	atrlf_pkg::byte_t            cur_e, pos_e, prev_e, prev2_e;
	logic                        zero_seen_e;
	logic                        header;

	// reply match and position bookkeeping
	assign hit = !zero_seen_q && (rx_byte != '0) &&
		((rx_byte == atrlf_pkg::CharGt) ||
		 (rx_byte == atrlf_pkg::CharK && prev_q == atrlf_pkg::CharO));
	assign pos_inc = {1'b0, pos_q} + 1'b1;

	// command mode: clear at the wrap point, byte then reads as zero
	assign wrap        = ({1'b0, pos_q} >= WrapLimit);
	assign cur_e       = wrap ? '0 : rx_byte;
	assign pos_e       = wrap ? '0 : pos_q;
	assign prev_e      = wrap ? '0 : prev_q;
	assign prev2_e     = wrap ? '0 : prev2_q;
	assign zero_seen_e = wrap ? 1'b0 : zero_seen_q;
	assign header      = (pos_e > atrlf_pkg::HeaderMinPos) && (prev2_e == '0) &&
		(prev_e == '0) && (cur_e != '0);

	// next state and result
	always_comb begin
		pos_d       = pos_q;
		prev_d      = prev_q;
		prev2_d     = prev2_q;
		zero_seen_d = zero_seen_q;
		remaining_d = remaining_q;
		msg_idx_d   = msg_idx_q;
		res         = '0;
		if (reply_mode_q) begin
			if (hit) begin
				res.ok_seen = 1'b1;
				pos_d       = '0;
				prev_d      = '0;
				prev2_d     = '0;
				zero_seen_d = 1'b0;
			end else if (pos_inc >= WrapLimit) begin
				pos_d       = '0;
				prev_d      = '0;
				prev2_d     = '0;
				zero_seen_d = 1'b0;
			end else begin
				pos_d       = pos_inc[atrlf_pkg::ByteW-1:0];
				prev_d      = rx_byte;
				prev2_d     = prev_q;
				zero_seen_d = zero_seen_q | (rx_byte == '0);
			end
		end else begin
			res.ok_seen = 1'b1;
			if (remaining_q != '0) begin
				res.msg_valid = 1'b1;
				res.msg_byte  = cur_e;
				res.msg_index = msg_idx_q;
				res.msg_last  = (remaining_q == 8'd1);
				msg_idx_d     = msg_idx_q + 1'b1;
				remaining_d   = remaining_q - 1'b1;
			end
			if (header) begin
				res.frame_start  = 1'b1;
				res.frame_length = cur_e;
				remaining_d      = cur_e;
				msg_idx_d        = '0;
			end
			pos_d       = pos_e + 1'b1;
			prev_d      = cur_e;
			prev2_d     = prev_e;
			zero_seen_d = zero_seen_e | (cur_e == '0);
		end
	end

	// state registers, updated on each accepted byte; reply mode on a config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_mode_q <= 1'b0;
			pos_q        <= '0;
			prev_q       <= '0;
			prev2_q      <= '0;
			zero_seen_q  <= 1'b0;
			remaining_q  <= '0;
			msg_idx_q    <= '0;
		end else begin
			if (cfg_we) begin
				reply_mode_q <= cfg_wdata;
			end
			if (in_fire) begin
				pos_q       <= pos_d;
				prev_q      <= prev_d;
				prev2_q     <= prev2_d;
				zero_seen_q <= zero_seen_d;
				remaining_q <= remaining_d;
				msg_idx_q   <= msg_idx_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/atrlf_outbuf.sv =====
// two-entry output buffer: result register plus skid register
// depends on atrlf_pkg
`default_nettype none

module atrlf_outbuf (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire atrlf_pkg::res_t push_data,
	output logic                 push_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output atrlf_pkg::res_t      out_data
);

	logic            main_valid_q, skid_valid_q;
	atrlf_pkg::res_t main_q, skid_q;

	assign push_ready = !skid_valid_q;
	assign out_valid  = main_valid_q;
	assign out_data   = main_q;

	// control: refill the result register from skid first, else from input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || out_ready) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (!main_valid_q || out_ready) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/at_reply_and_length_frame_parser.sv =====
// a result is registered in the output buffer when its byte request is accepted
// throughput: one byte per cycle, sustained while results are taken each cycle
// a two-entry output buffer keeps input ready while one result is stalled
// reset (arst_n low) clears reply_mode, the buffer state, message count and index
// depends on atrlf_pkg, atrlf_rx_if, atrlf_res_if, atrlf_core, atrlf_outbuf
`default_nettype none

module at_reply_and_length_frame_parser #(
	parameter int unsigned WRAP_LIMIT = 150
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	atrlf_rx_if.sink    rx,
	atrlf_res_if.source res
);

	logic            in_fire;
	logic            push_ready;
	atrlf_pkg::res_t core_res;
	atrlf_pkg::res_t out_data;

	assign rx.ready = push_ready;
	assign in_fire  = rx.valid && push_ready;

	// state and single-pass parse
	atrlf_core #(
		.WRAP_LIMIT (WRAP_LIMIT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_fire   (in_fire),
		.rx_byte   (rx.rx_byte),
		.res       (core_res)
	);

	// result register and skid
	atrlf_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_fire),
		.push_data  (core_res),
		.push_ready (push_ready),
		.out_valid  (res.valid),
		.out_ready  (res.ready),
		.out_data   (out_data)
	);

	// unpack the result
	assign res.ok_seen      = out_data.ok_seen;
	assign res.frame_start  = out_data.frame_start;
	assign res.frame_length = out_data.frame_length;
	assign res.msg_valid    = out_data.msg_valid;
	assign res.msg_byte     = out_data.msg_byte;
	assign res.msg_index    = out_data.msg_index;
	assign res.msg_last     = out_data.msg_last;

endmodule

`default_nettype wire

// ===== src/atrlf_check.sv =====
// port-level checks on the result channel of the parser, bound to the top level
// depends on atrlf_pkg and at_reply_and_length_frame_parser
`default_nettype none

module atrlf_check (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid,
	input  wire logic             ready,
	input  wire logic             ok_seen,
	input  wire logic             frame_start,
	input  wire atrlf_pkg::byte_t frame_length,
	input  wire logic             msg_valid,
	input  wire atrlf_pkg::byte_t msg_byte,
	input  wire atrlf_pkg::byte_t msg_index,
	input  wire logic             msg_last
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(frame_length) &&
		$stable(msg_byte) && $stable(msg_index) && $stable(ok_seen))
		else $error("result changed while stalled");

	// length is zero without a header and nonzero with one
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (frame_start == (frame_length != '0)))
		else $error("frame_length inconsistent with frame_start");

	// message fields are zero outside a message
	a_msg: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !msg_valid |->
		msg_byte == '0 && msg_index == '0 && !msg_last)
		else $error("message fields set without msg_valid");

	// no frame activity in reply mode (the only case without ok)
	a_reply: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ok_seen |-> !frame_start && !msg_valid)
		else $error("frame output without ok");

endmodule

bind at_reply_and_length_frame_parser atrlf_check u_atrlf_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (res.valid),
	.ready        (res.ready),
	.ok_seen      (res.ok_seen),
	.frame_start  (res.frame_start),
	.frame_length (res.frame_length),
	.msg_valid    (res.msg_valid),
	.msg_byte     (res.msg_byte),
	.msg_index    (res.msg_index),
	.msg_last     (res.msg_last)
);

`default_nettype wire

// ===== sim/at_reply_and_length_frame_parser_tb.sv =====
// testbench for the reply and length frame parser: directed bytes, then random reply
// text and command frames under changing idle and stall patterns, checked by a scoreboard
// depends on atrlf_pkg, atrlf_rx_if, atrlf_res_if and the at_reply_and_length_frame_parser top

// mirrors the parser state and checks each result against its own prediction
class parser_scoreboard #(int unsigned WRAP_LIMIT = 150);
	bit                reply_mode;
	atrlf_pkg::byte_t  position;
	atrlf_pkg::byte_t  prev_byte;
	atrlf_pkg::byte_t  prev_prev_byte;
	bit                zero_seen;
	atrlf_pkg::byte_t  remaining;
	atrlf_pkg::byte_t  message_index;
	atrlf_pkg::res_t   parser_outputs[$];
	int                errors;
	int                results;
	int                frames;
	int                replies;

	function void clear_buffer();
		position       = '0;
		prev_byte      = '0;
		prev_prev_byte = '0;
		zero_seen      = 1'b0;
	endfunction

	function void reset_state();
		reply_mode    = 1'b0;
		clear_buffer();
		remaining     = '0;
		message_index = '0;
	endfunction

	function void store_byte(atrlf_pkg::byte_t b);
		if (b == 8'h00) zero_seen = 1'b1;
		prev_prev_byte = prev_byte;
		prev_byte      = b;
	endfunction

	// note an accepted request and work out the result it causes
	function void parse_byte(atrlf_pkg::byte_t b);
		atrlf_pkg::res_t  r;
		atrlf_pkg::byte_t cur;
		bit               hit;
		int unsigned      next_pos;
		r   = '0;
		cur = b;
		if (reply_mode) begin
			hit = !zero_seen && cur != 8'h00 &&
				(cur == atrlf_pkg::CharGt ||
				 (cur == atrlf_pkg::CharK && prev_byte == atrlf_pkg::CharO));
			if (hit) begin
				clear_buffer();
				r.ok_seen = 1'b1;
				replies++;
			end else begin
				next_pos = position + 1;
				store_byte(cur);
				if (next_pos >= WRAP_LIMIT) clear_buffer();
				else position = atrlf_pkg::byte_t'(next_pos);
			end
		end else begin
			r.ok_seen = 1'b1;
			// buffer full: wraps and the byte reads as zero
			if (position >= WRAP_LIMIT) begin
				clear_buffer();
				cur = 8'h00;
			end
			if (remaining != 8'h00) begin
				r.msg_valid   = 1'b1;
				r.msg_byte    = cur;
				r.msg_index   = message_index;
				r.msg_last    = (remaining == 8'h01);
				message_index = message_index + 8'h01;
				remaining     = remaining - 8'h01;
			end
			// length header after two zeros, overrides a pending count
			if (position > atrlf_pkg::HeaderMinPos && prev_prev_byte == 8'h00 &&
				prev_byte == 8'h00 && cur != 8'h00) begin
				r.frame_start  = 1'b1;
				r.frame_length = cur;
				remaining      = cur;
				message_index  = '0;
				frames++;
			end
			store_byte(cur);
			position = position + 8'h01;
		end
		parser_outputs.push_back(r);
	endfunction

	function void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endfunction

	// compare one accepted result with the oldest outstanding one
	function void check_result(atrlf_pkg::res_t got);
		atrlf_pkg::res_t want;
		results++;
		if (parser_outputs.size() == 0) begin
			errors++;
			$display("%0t: result with none outstanding, expected nothing, actual 0x%0h",
				$time, got);
		end else begin
			want = parser_outputs.pop_front();
			check_field("ok_seen", want.ok_seen, got.ok_seen);
			check_field("frame_start", want.frame_start, got.frame_start);
			check_field("frame_length", want.frame_length, got.frame_length);
			check_field("msg_valid", want.msg_valid, got.msg_valid);
			check_field("msg_byte", want.msg_byte, got.msg_byte);
			check_field("msg_index", want.msg_index, got.msg_index);
			check_field("msg_last", want.msg_last, got.msg_last);
		end
	endfunction

	function int pending();
		return parser_outputs.size();
	endfunction
endclass

module at_reply_and_length_frame_parser_tb;

	localparam int unsigned WrapLimit   = 150;
	localparam int unsigned RandomItems = 1350;
	localparam int unsigned CycleLimit  = 200000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	int          idle_pct;
	int          stall_pct;
	int unsigned cycles;
	int unsigned sent;

	parser_scoreboard #(WrapLimit) sb;

	atrlf_rx_if  rx();
	atrlf_res_if res();

	at_reply_and_length_frame_parser #(
		.WRAP_LIMIT(WrapLimit)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx),
		.res       (res)
	);

	// clock, period 8
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
				sb.pending());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		res.ready <= ($urandom_range(99) >= stall_pct);
	end

	// watch both handshakes; results first so a request cannot match its own edge
	always @(posedge clk) begin : watch
		atrlf_pkg::res_t got;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				got.ok_seen      = res.ok_seen;
				got.frame_start  = res.frame_start;
				got.frame_length = res.frame_length;
				got.msg_valid    = res.msg_valid;
				got.msg_byte     = res.msg_byte;
				got.msg_index    = res.msg_index;
				got.msg_last     = res.msg_last;
				sb.check_result(got);
			end
			if (rx.valid && rx.ready) sb.parse_byte(rx.rx_byte);
		end
	end

	// one request, with a random gap in front of it
	task automatic send_byte(input atrlf_pkg::byte_t b);
		while ($urandom_range(99) < idle_pct) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
		sent++;
	endtask

	// hold off until every outstanding result has been taken
	task automatic drain();
		rx.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_mode(input bit m);
		drain();
		repeat (2) @(posedge clk);
		cfg_wdata <= m;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we        <= 1'b0;
		sb.reply_mode = m;
	endtask

	task automatic set_idle(input int phase);
		case (phase)
			0: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct  = 62;
				stall_pct = 0;
			end
			2: begin
				idle_pct  = 0;
				stall_pct = 62;
			end
			default: begin
				idle_pct  = 9;
				stall_pct = 9;
			end
		endcase
	endtask

	function automatic atrlf_pkg::byte_t noise_byte();
		if ($urandom_range(15) == 0) return 8'h00;
		return atrlf_pkg::byte_t'($urandom_range(255));
	endfunction

	// padding, two zeros, a length header and a body that is sometimes cut short
	task automatic send_frame();
		int unsigned pad;
		int unsigned len;
		int unsigned body;
		int unsigned r;
		pad = $urandom_range(5);
		repeat (pad) send_byte(noise_byte());
		send_byte(8'h00);
		send_byte(8'h00);
		r = $urandom_range(99);
		if (r == 0) len = 255;
		else if (r < 8) len = $urandom_range(13, 80);
		else len = $urandom_range(1, 12);
		send_byte(atrlf_pkg::byte_t'(len));
		body = ($urandom_range(7) == 0) ? $urandom_range(len) : len;
		repeat (body) send_byte(noise_byte());
	endtask

	// module reply text; sparse text holds no match so the buffer wraps
	task automatic send_reply_text(input int unsigned n, input bit sparse);
		atrlf_pkg::byte_t c;
		int unsigned      r;
		repeat (n) begin
			if (sparse) begin
				c = atrlf_pkg::byte_t'($urandom_range(255));
				if (c == atrlf_pkg::CharGt || c == atrlf_pkg::CharK) c = atrlf_pkg::CharO;
				send_byte(c);
			end else begin
				r = $urandom_range(59);
				if (r < 12) begin
					send_byte(atrlf_pkg::CharO);
					if (r < 6) send_byte(atrlf_pkg::CharK);
				end else if (r < 20) send_byte(atrlf_pkg::CharK);
				else if (r < 24) send_byte(atrlf_pkg::CharGt);
				else if (r == 59) send_byte(8'h00);
				else send_byte(atrlf_pkg::byte_t'($urandom_range(1, 255)));
			end
		end
	endtask

	// stimulus
	initial begin : stim
		atrlf_pkg::byte_t cmd_bytes[$];
		atrlf_pkg::byte_t reply_bytes[$];
		int unsigned      burst;
		int unsigned      target;
		int unsigned      start;
		bit               mode;
		sb = new();
		sb.reset_state();
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = 1'b0;
		rx.valid   = 1'b0;
		rx.rx_byte = 8'h00;
		res.ready  = 1'b0;
		idle_pct   = 0;
		stall_pct  = 0;
		cycles     = 0;
		sent       = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// command mode: header too early, header, message, header during a message
		cmd_bytes = {8'h00, 8'h00, 8'h07, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h03, 8'hAA, 8'h55,
			8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h02, 8'h11};
		write_mode(1'b0);
		foreach (cmd_bytes[i]) send_byte(cmd_bytes[i]);

		// reply mode with a message still pending: matches, a miss, then a zero blocking '>'
		reply_bytes = {atrlf_pkg::CharO, atrlf_pkg::CharK, atrlf_pkg::CharGt, atrlf_pkg::CharO,
			8'h78, atrlf_pkg::CharK, 8'h00, atrlf_pkg::CharGt};
		write_mode(1'b1);
		foreach (reply_bytes[i]) send_byte(reply_bytes[i]);

		// random bursts across modes and idle patterns
		burst = 0;
		start = sent;
		while (sent - start < RandomItems) begin
			set_idle(burst % 4);
			mode = (burst % 3 == 1);
			write_mode(mode);
			target = sent + $urandom_range(60, 140);
			if (mode) begin
				if (burst % 5 == 4) send_reply_text(target - sent + 40, 1'b1);
				else send_reply_text(target - sent, 1'b0);
			end else begin
				while (sent < target) begin
					if ($urandom_range(7) == 0) repeat ($urandom_range(1, 8)) send_byte(noise_byte());
					else send_frame();
				end
				// leave the buffer exactly at the limit for the next burst
				if (burst % 2 == 0) begin
					drain();
					repeat (WrapLimit - sb.position)
						send_byte(atrlf_pkg::byte_t'($urandom_range(1, 255)));
				end
			end
			burst++;
		end

		drain();
		repeat (5) @(posedge clk);
		$display("%0d bytes sent in %0d bursts, %0d results checked in %0d cycles",
			sent, burst, sb.results, cycles);
		$display("%0d command frames and %0d module replies seen under four idle patterns",
			sb.frames, sb.replies);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
